>>> src/slsfr_pkg.sv
// shared types and constants of the sync/length/sum frame receiver
package slsfr_pkg;

    // default payload buffer depth
    localparam int MAX_PAYLOAD_DEF = 32;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = 5;
    localparam int LEN_W    = 6;
    localparam int SUM_W    = 16;
    localparam int TDATA_W  = 24;
    localparam int TUSER_W  = 4;

    // framing bytes
    localparam logic [BYTE_W-1:0] SYNC_A = 8'hA5;
    localparam logic [BYTE_W-1:0] SYNC_B = 8'h5A;
    localparam logic [BYTE_W-1:0] END_A  = 8'hCC;
    localparam logic [BYTE_W-1:0] END_B  = 8'h33;

    // status codes
    localparam logic [STATUS_W-1:0] ST_GOOD  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CSUM  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_START = 3'd2;
    localparam logic [STATUS_W-1:0] ST_END   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LEN   = 3'd4;

    // one result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                has_data;
        logic [BYTE_W-1:0]   data_byte;
        logic [IDX_W-1:0]    byte_index;
        logic [LEN_W-1:0]    frame_length;
        logic                last;
    } out_item_t;

endpackage

>>> src/slsfr_ram.sv
// generic single-write, single-read ram with registered read data
module slsfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data holds while not reading
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/slsfr_parser.sv
// frame state machine: sync hunt, length, payload capture, checksum and end check
module slsfr_parser import slsfr_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1),
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_accept,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [BYTE_W-1:0] wr_data,
    output logic              res_valid,
    output out_item_t         res,
    output logic              drain_start,
    output logic [CNT_W-1:0]  drain_count
);

    // frame phases
    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_SYNC2   = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CSUM_HI = 3'd4;
    localparam logic [2:0] PH_CSUM_LO = 3'd5;
    localparam logic [2:0] PH_END1    = 3'd6;
    localparam logic [2:0] PH_END2    = 3'd7;

    localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);

    logic [2:0]       phase_reg, phase_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0] rsum_reg, rsum_next;
    logic [CNT_W-1:0] explen_reg, explen_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] count_inc;

    // single-beat status result
    function automatic out_item_t status_item(logic [STATUS_W-1:0] st,
                                              logic [LEN_W-1:0] len);
        out_item_t it;
        it              = '0;
        it.status       = st;
        it.frame_length = len;
        it.last         = 1'b1;
        return it;
    endfunction

    assign count_inc   = count_reg + CNT_W'(1);
    assign wr_addr     = count_reg[ADDR_W-1:0];
    assign wr_data     = rx_byte;
    assign drain_count = count_reg;

    // next state and results for the accepted byte
    always_comb
    begin
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        rsum_next   = rsum_reg;
        explen_next = explen_reg;
        count_next  = count_reg;
        res_valid   = 1'b0;
        res         = '0;
        wr_en       = 1'b0;
        drain_start = 1'b0;
        if (in_accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == SYNC_A)
                    begin
                        sum_next   = '0;
                        phase_next = PH_SYNC2;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        res       = status_item(ST_START, '0);
                    end
                end
                PH_SYNC2:
                begin
                    if (rx_byte == SYNC_B)
                    begin
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        res        = status_item(ST_START, '0);
                        phase_next = PH_HUNT;
                    end
                end
                PH_LEN:
                begin
                    sum_next = sum_reg + SUM_W'(rx_byte);
                    if (rx_byte > MAX_LEN)
                    begin
                        res_valid  = 1'b1;
                        res        = status_item(ST_LEN, '0);
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        explen_next = CNT_W'(rx_byte);
                        count_next  = '0;
                        phase_next  = (rx_byte == '0) ? PH_CSUM_HI : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    wr_en      = 1'b1;
                    sum_next   = sum_reg + SUM_W'(rx_byte);
                    count_next = count_inc;
                    if (count_inc == explen_reg)
                    begin
                        phase_next = PH_CSUM_HI;
                    end
                end
                PH_CSUM_HI:
                begin
                    rsum_next  = {rx_byte, 8'h00};
                    phase_next = PH_CSUM_LO;
                end
                PH_CSUM_LO:
                begin
                    rsum_next  = {rsum_reg[SUM_W-1:BYTE_W], rx_byte};
                    phase_next = PH_END1;
                end
                PH_END1:
                begin
                    if (rx_byte == END_A)
                    begin
                        phase_next = PH_END2;
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        res        = status_item(ST_END, '0);
                        phase_next = PH_HUNT;
                    end
                end
                PH_END2:
                begin
                    // other bytes are ignored while waiting for the closing byte
                    if (rx_byte == END_B)
                    begin
                        phase_next = PH_HUNT;
                        if (rsum_reg == sum_reg)
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid = 1'b1;
                                res       = status_item(ST_GOOD, '0);
                            end
                            else
                            begin
                                drain_start = 1'b1;
                            end
                        end
                        else
                        begin
                            res_valid = 1'b1;
                            res       = status_item(ST_CSUM, LEN_W'(explen_reg));
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            sum_reg    <= '0;
            rsum_reg   <= '0;
            explen_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            sum_reg    <= sum_next;
            rsum_reg   <= rsum_next;
            explen_reg <= explen_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/slsfr_emitter.sv
// payload readout from the buffer ram and output register with skid stage
module slsfr_emitter import slsfr_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1),
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  out_item_t         res,
    input  logic              drain_start,
    input  logic [CNT_W-1:0]  drain_count,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [BYTE_W-1:0] rd_data,
    output logic              in_ok,
    output logic              m_valid,
    output out_item_t         m_item,
    input  logic              m_ready
);

    logic             drain_reg, drain_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] didx_reg, didx_next;
    logic             rdv_reg, rdv_next;
    logic [CNT_W-1:0] ptr_inc;
    logic [CNT_W-1:0] cnt_dec;

    logic             out_valid_reg, skid_valid_reg;
    out_item_t        out_reg, skid_reg;

    logic             ram_push;
    logic             push;
    out_item_t        push_item;
    out_item_t        ram_item;
    logic             out_free;

    assign ptr_inc  = ptr_reg + CNT_W'(1);
    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign out_free = !out_valid_reg || m_ready;

    // ram data stage moves on once the skid stage has room
    assign ram_push = rdv_reg && !skid_valid_reg;
    assign rd_en    = drain_reg && (!rdv_reg || ram_push);
    assign rd_addr  = ptr_reg[ADDR_W-1:0];

    // input side may run only with no readout going on and a free skid slot
    assign in_ok = !drain_reg && !rdv_reg && !skid_valid_reg;

    // payload beat built from the ram data
    always_comb
    begin
        ram_item              = '0;
        ram_item.status       = ST_GOOD;
        ram_item.has_data     = 1'b1;
        ram_item.data_byte    = rd_data;
        ram_item.byte_index   = IDX_W'(didx_reg);
        ram_item.frame_length = LEN_W'(cnt_reg);
        ram_item.last         = (didx_reg == cnt_dec);
    end

    assign push      = ram_push || res_valid;
    assign push_item = ram_push ? ram_item : res;

    // readout sequencer
    always_comb
    begin
        drain_next = drain_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        didx_next  = didx_reg;
        rdv_next   = rdv_reg;
        if (ram_push)
        begin
            rdv_next = 1'b0;
        end
        if (rd_en)
        begin
            rdv_next  = 1'b1;
            didx_next = ptr_reg;
            ptr_next  = ptr_inc;
            if (ptr_inc == cnt_reg)
            begin
                drain_next = 1'b0;
            end
        end
        if (drain_start)
        begin
            drain_next = 1'b1;
            ptr_next   = '0;
            cnt_next   = drain_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg <= 1'b0;
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            didx_reg  <= '0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            drain_reg <= drain_next;
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
            didx_reg  <= didx_next;
            rdv_reg   <= rdv_next;
        end
    end

    // output register and skid stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output register and skid stage payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (push)
            begin
                out_reg <= push_item;
            end
        end
        else if (push)
        begin
            skid_reg <= push_item;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

>>> src/sync_length_sum_frame_receiver_top.sv
// Sync/length/sum frame receiver, top level.
//
// Input channel s_axis: one received serial byte per beat in s_axis_tdata.
// The block hunts for the sync pair A5 5A, reads a length byte and that many
// payload bytes into a buffer ram, then a big-endian 16-bit checksum and the
// end pair CC 33. Output channel m_axis: status beats for start, end, length
// and checksum errors, one empty-frame beat for a good zero-length frame, or
// the payload of a good frame as one beat per byte, tlast on the final beat.
//
// Results are registered; payload bytes also pass the ram read data register.
// Throughput: one input byte per cycle while s_axis_tready is high. A good
// frame of N payload bytes is read out of the buffer ram at one byte per cycle
// (single read port) while m_axis keeps up, and s_axis_tready stays low until
// the readout has left the ram and skid stage. An output register plus a skid
// stage keep input going while one result waits; once a second result fills
// the skid, s_axis_tready drops until m_axis drains.
// Reset: rst_n clears the frame state to hunting; buffer ram contents are not
// cleared, only bytes written by the current frame are ever read out.
module sync_length_sum_frame_receiver_top import slsfr_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [7:0] data_byte, [12:8] byte_index,
                                               // [18:13] frame_length, [23:19] zero
    output logic [TUSER_W-1:0] m_axis_tuser,   // [2:0] status, [3] has_data
    output logic               m_axis_tlast
);

    localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic              in_accept;
    logic              in_ok;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              res_valid;
    out_item_t         res;
    logic              drain_start;
    logic [CNT_W-1:0]  drain_count;
    out_item_t         m_item;

    assign s_axis_tready = in_ok;
    assign in_accept     = s_axis_tvalid && in_ok;

    // frame parser
    slsfr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .rx_byte     (s_axis_tdata),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .res_valid   (res_valid),
        .res         (res),
        .drain_start (drain_start),
        .drain_count (drain_count)
    );

    // payload buffer
    slsfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // readout and output stage
    slsfr_emitter #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_valid   (res_valid),
        .res         (res),
        .drain_start (drain_start),
        .drain_count (drain_count),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .in_ok       (in_ok),
        .m_valid     (m_axis_tvalid),
        .m_item      (m_item),
        .m_ready     (m_axis_tready)
    );

    // output packing
    assign m_axis_tdata = {{(TDATA_W - BYTE_W - IDX_W - LEN_W){1'b0}},
                           m_item.frame_length, m_item.byte_index, m_item.data_byte};
    assign m_axis_tuser = {m_item.has_data, m_item.status};
    assign m_axis_tlast = m_item.last;

endmodule

>>> src/slsfr_checker.sv
// port-level checks for the frame receiver, bound to the top level
module slsfr_checker import slsfr_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic [TUSER_W-1:0] m_axis_tuser,
    input logic               m_axis_tlast
);

    // a stalled beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    // a stalled beat keeps its content
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // payload bytes only come from good frames
    a_data_good: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[2:0] == ST_GOOD)
        else $error("payload byte with error status");

    // status-only results are single beats
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[3] |-> m_axis_tlast)
        else $error("status beat without tlast");

    // input is held off while a payload readout is still under way
    a_drain_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[3] && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken during payload readout");

endmodule

bind sync_length_sum_frame_receiver_top slsfr_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
